@@ sv/cfra_pkg.sv @@
// Shared types and constants for the continued-fraction rational approximation block.
// Holds the sequencer state encoding and the fixed field widths; no dependencies.
`timescale 1ns / 1ps

package cfra_pkg;

    // Fixed field widths of the stream and configuration ports
    localparam int IN_W  = 48;
    localparam int NUM_W = 32;
    localparam int DEN_W = 16;
    localparam int CFG_W = 16;

    // Largest partial quotient the expansion will take
    localparam logic [63:0] REP_LIMIT = 64'h0000_0000_7FFF_FFFF;

    // Width of the multiplier's second operand (a partial quotient after the limit test)
    localparam int AI_W = 31;

    // Sequencer states, one-hot
    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_DIV  = 7'b0000010,
        ST_TEST = 7'b0000100,
        ST_MULD = 7'b0001000,
        ST_CMP  = 7'b0010000,
        ST_UPD  = 7'b0100000,
        ST_DONE = 7'b1000000
    } state_t;

endpackage

@@ sv/continued_fraction_rational_approx_top.sv @@
// Continued-fraction best rational approximation: top level with sequencer, divider
// and shared multiplier. Depends on cfra_pkg.
`timescale 1ns / 1ps

// Takes one unsigned Q(48-FRAC_BITS).FRAC_BITS value per transaction and returns
// the last continued-fraction convergent whose denominator fits max_denominator.
// The integer part is split off in the accept cycle; every further term runs one
// restoring divider (one quotient bit a cycle) followed by a limit test, two passes
// through one shared 32x31 multiplier and a convergent update. The input is ready
// only while the sequencer is idle; a finished result sits in an output register,
// so the next item can be taken while it waits.

module continued_fraction_rational_approx_top #(
    parameter int FRAC_BITS = 32,
    parameter int DEN_BITS  = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // Input stream; tdata: real_value[47:0]
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [cfra_pkg::IN_W-1:0]   s_axis_tdata,
    // Result stream; tdata: numerator[31:0], denominator[47:32]
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [cfra_pkg::NUM_W+cfra_pkg::DEN_W-1:0] m_axis_tdata,
    // max_denominator register write
    input  logic                        cfg_wr_en,
    input  logic [cfra_pkg::CFG_W-1:0]  cfg_wr_data
);

    localparam int W     = FRAC_BITS + 1;
    localparam int CNT_W = $clog2(W);
    localparam int AI0_W = cfra_pkg::IN_W - FRAC_BITS;
    localparam int PROD_W = cfra_pkg::NUM_W + cfra_pkg::AI_W;

    cfra_pkg::state_t state_reg, state_next;

    logic [DEN_BITS-1:0]          max_den_reg;
    logic [W-1:0]                 quo_reg, quo_next;
    logic [W-1:0]                 rem_reg, rem_next;
    logic [W-1:0]                 q_reg, q_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic [cfra_pkg::NUM_W-1:0]   n0_reg, n0_next, n1_reg, n1_next;
    logic [DEN_BITS-1:0]          d0_reg, d0_next, d1_reg, d1_next;
    logic [DEN_BITS-1:0]          nd_reg, nd_next;
    logic [PROD_W-1:0]            prod_reg, prod_next;
    logic                         out_valid_reg, out_valid_next;
    logic [cfra_pkg::NUM_W+cfra_pkg::DEN_W-1:0] out_data_reg, out_data_next;

    logic [W:0]                   trial;
    logic                         trial_ge;
    logic [cfra_pkg::NUM_W-1:0]   mul_a;
    logic [cfra_pkg::AI_W-1:0]    mul_b;
    logic [63:0]                  nd_full;
    logic                         beyond;
    logic [AI0_W-1:0]             ai0;
    logic [FRAC_BITS-1:0]         r0;
    logic                         in_fire;

    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == cfra_pkg::ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Split the input into integer part and fraction
    assign ai0 = s_axis_tdata[cfra_pkg::IN_W-1:FRAC_BITS];
    assign r0  = s_axis_tdata[FRAC_BITS-1:0];

    // One restoring division step
    assign trial    = {rem_reg, quo_reg[W-1]};
    assign trial_ge = trial >= {1'b0, q_reg};

    // Shared multiplier: denominator product, then numerator product
    assign mul_a = (state_reg == cfra_pkg::ST_CMP) ? n0_reg : cfra_pkg::NUM_W'(d0_reg);
    assign mul_b = cfra_pkg::AI_W'(quo_reg);

    // Candidate denominator and partial quotient limit test
    assign nd_full = 64'(prod_reg) + 64'(d1_reg);
    assign beyond  = (64'(quo_reg) > cfra_pkg::REP_LIMIT) ||
                     ((64'(quo_reg) == cfra_pkg::REP_LIMIT) && (rem_reg != '0));

    // Sequencer and datapath next state
    always_comb
    begin
        state_next     = state_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        q_next         = q_reg;
        cnt_next       = cnt_reg;
        n0_next        = n0_reg;
        n1_next        = n1_reg;
        d0_next        = d0_reg;
        d1_next        = d1_reg;
        nd_next        = nd_reg;
        prod_next      = prod_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        // Drop the result once the consumer takes it
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            cfra_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    // First term comes straight from the integer part
                    n0_next  = cfra_pkg::NUM_W'(ai0);
                    n1_next  = cfra_pkg::NUM_W'(1);
                    d0_next  = DEN_BITS'(1);
                    d1_next  = '0;
                    quo_next = W'(1) << FRAC_BITS;
                    q_next   = W'(r0);
                    rem_next = '0;
                    cnt_next = CNT_W'(W - 1);
                    if ((max_den_reg == '0) || (r0 == '0))
                    begin
                        state_next = cfra_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = cfra_pkg::ST_DIV;
                    end
                end
            end
            cfra_pkg::ST_DIV:
            begin
                rem_next = trial_ge ? W'(trial - {1'b0, q_reg}) : trial[W-1:0];
                quo_next = {quo_reg[W-2:0], trial_ge};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = cfra_pkg::ST_TEST;
                end
            end
            cfra_pkg::ST_TEST:
            begin
                // Stop when the partial quotient exceeds the representation limit
                if (beyond)
                begin
                    state_next = cfra_pkg::ST_DONE;
                end
                else
                begin
                    state_next = cfra_pkg::ST_MULD;
                end
            end
            cfra_pkg::ST_MULD:
            begin
                prod_next  = PROD_W'(mul_a * mul_b);
                state_next = cfra_pkg::ST_CMP;
            end
            cfra_pkg::ST_CMP:
            begin
                // Keep the previous convergent if the denominator outgrows the limit
                nd_next   = DEN_BITS'(nd_full);
                prod_next = PROD_W'(mul_a * mul_b);
                if (nd_full > 64'(max_den_reg))
                begin
                    state_next = cfra_pkg::ST_DONE;
                end
                else
                begin
                    state_next = cfra_pkg::ST_UPD;
                end
            end
            cfra_pkg::ST_UPD:
            begin
                // Advance the convergent matrix and the Euclid pair
                n0_next = prod_reg[cfra_pkg::NUM_W-1:0] + n1_reg;
                n1_next = n0_reg;
                d0_next = nd_reg;
                d1_next = d0_reg;
                if (rem_reg == '0)
                begin
                    state_next = cfra_pkg::ST_DONE;
                end
                else
                begin
                    quo_next   = q_reg;
                    q_next     = rem_reg;
                    rem_next   = '0;
                    cnt_next   = CNT_W'(W - 1);
                    state_next = cfra_pkg::ST_DIV;
                end
            end
            cfra_pkg::ST_DONE:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {cfra_pkg::DEN_W'(d0_reg), n0_reg};
                    state_next     = cfra_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cfra_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cfra_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            max_den_reg   <= DEN_BITS'(16'hFFFF);
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                max_den_reg <= DEN_BITS'(cfg_wr_data);
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        q_reg        <= q_next;
        cnt_reg      <= cnt_next;
        n0_reg       <= n0_next;
        n1_reg       <= n1_next;
        d0_reg       <= d0_next;
        d1_reg       <= d1_next;
        nd_reg       <= nd_next;
        prod_reg     <= prod_next;
        out_data_reg <= out_data_next;
    end

endmodule

@@ sim/cfra_result_monitor.sv @@
// Result monitor for the continued-fraction rational approximation block: predicts each
// convergent from the accepted input and compares it with the result stream.
// Depends on cfra_pkg for field widths and the partial-quotient cap.
`timescale 1ns / 1ps

module cfra_result_monitor (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         in_valid,
    input  logic                                         in_ready,
    input  logic [cfra_pkg::IN_W-1:0]                    in_data,
    input  logic                                         out_valid,
    input  logic                                         out_ready,
    input  logic [cfra_pkg::NUM_W+cfra_pkg::DEN_W-1:0]   out_data,
    input  logic                                         cfg_wr_en,
    input  logic [cfra_pkg::CFG_W-1:0]                   cfg_wr_data,
    output int                                           pending,
    output int                                           fail_count
);

    localparam int FRAC_BITS = 32;

    typedef struct packed {
        logic [cfra_pkg::DEN_W-1:0] den;
        logic [cfra_pkg::NUM_W-1:0] num;
    } fraction_t;

    logic [cfra_pkg::CFG_W-1:0] den_limit;
    fraction_t                  expected_fractions[$];
    fraction_t                  want;
    fraction_t                  got;

    // Exact test of q / r against the largest partial quotient allowed
    function automatic bit quotient_exceeds_cap(input logic [63:0] q, input logic [63:0] r);
        logic [63:0] whole;
        whole = q / r;
        if (whole > cfra_pkg::REP_LIMIT)
            return 1'b1;
        if (whole == cfra_pkg::REP_LIMIT)
            return (q % r) != 0;
        return 1'b0;
    endfunction

    // Walk the Euclid pair (value, 2^FRAC_BITS) and keep the last convergent that fits
    function automatic fraction_t best_convergent(input logic [cfra_pkg::IN_W-1:0] value,
                                                  input logic [cfra_pkg::CFG_W-1:0] lim);
        logic [63:0] p;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] ai;
        logic [63:0] next_den;
        logic [63:0] next_num;
        logic [63:0] num_cur;
        logic [63:0] num_prev;
        logic [63:0] den_cur;
        logic [63:0] den_prev;
        int unsigned steps;
        bit          stop;
        fraction_t   f;
        p        = {16'd0, value};
        q        = 64'd1 << FRAC_BITS;
        num_cur  = 64'd1;
        num_prev = 64'd0;
        den_cur  = 64'd0;
        den_prev = 64'd1;
        steps    = 0;
        stop     = 1'b0;
        while (!stop)
        begin
            ai       = p / q;
            r        = p % q;
            next_den = den_cur * ai + den_prev;
            if (next_den > {48'd0, lim})
                stop = 1'b1;
            else
            begin
                next_num = num_cur * ai + num_prev;
                num_prev = num_cur;
                num_cur  = next_num;
                den_prev = den_cur;
                den_cur  = next_den;
                if (r == 64'd0 || quotient_exceeds_cap(q, r))
                    stop = 1'b1;
                else
                begin
                    p = q;
                    q = r;
                    steps++;
                end
            end
        end
        // No completed term: integer part over one, even under a zero limit
        if (steps == 0)
        begin
            f.num = {16'd0, value[cfra_pkg::IN_W-1:FRAC_BITS]};
            f.den = 16'd1;
        end
        else
        begin
            f.num = num_cur[cfra_pkg::NUM_W-1:0];
            f.den = den_cur[cfra_pkg::DEN_W-1:0];
        end
        return f;
    endfunction

    // Track the limit, queue predictions, compare results in order
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            den_limit = 16'hFFFF;
            expected_fractions.delete();
            fail_count = 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                den_limit = cfg_wr_data;
            if (in_valid && in_ready)
                expected_fractions.push_back(best_convergent(in_data, den_limit));
            if (out_valid && out_ready)
            begin
                got = out_data;
                if (expected_fractions.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected result num=%0d den=%0d",
                                 $realtime, got.num, got.den);
                end
                else
                begin
                    want = expected_fractions.pop_front();
                    if (got.num !== want.num || got.den !== want.den)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: mismatch num exp=%0d got=%0d den exp=%0d got=%0d",
                                     $realtime, want.num, got.num, want.den, got.den);
                    end
                end
            end
            pending <= expected_fractions.size();
        end
    end

endmodule

@@ sim/tb.sv @@
// Testbench top for continued_fraction_rational_approx_top: clock, reset, input stream,
// result back-pressure, limit writes and verdict. Depends on cfra_pkg and cfra_result_monitor.
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT = 4000000;

    logic                                        clk = 1'b0;
    logic                                        rst_n = 1'b0;
    logic                                        in_valid = 1'b0;
    logic                                        in_ready;
    logic [cfra_pkg::IN_W-1:0]                   in_data = '0;
    logic                                        out_valid;
    logic                                        out_ready = 1'b0;
    logic [cfra_pkg::NUM_W+cfra_pkg::DEN_W-1:0]  out_data;
    logic                                        cfg_wr_en = 1'b0;
    logic [cfra_pkg::CFG_W-1:0]                  cfg_wr_data = '0;
    int                                          pending;
    int                                          fail_count;
    int unsigned                                 cycles = 0;

    // Receiver state
    int unsigned hold_left = 0;
    int unsigned mode_left = 0;
    int unsigned results_seen = 0;
    int unsigned stall_mode = 0;
    bit          long_hold_done = 1'b0;

    always #2 clk = ~clk;

    continued_fraction_rational_approx_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (in_valid),
        .s_axis_tready (in_ready),
        .s_axis_tdata  (in_data),
        .m_axis_tvalid (out_valid),
        .m_axis_tready (out_ready),
        .m_axis_tdata  (out_data),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    cfra_result_monitor mon (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .pending     (pending),
        .fail_count  (fail_count)
    );

    // Bound the run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("continued_fraction_rational_approx_top regression: fail");
            $finish;
        end
    end

    // Stall the result side on shifting patterns; hold off once for a long stretch
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
                results_seen++;
            if (!long_hold_done && results_seen == 150)
            begin
                hold_left      = 4000;
                long_hold_done = 1'b1;
            end
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(20, 300);
            end
            else
                mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                case (stall_mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    2:       out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= ~out_ready;
                endcase
        end
    end

    // Pick a Q16.32 value: exact-ish rationals, raw bits, values below four, near-integers and tiny values
    function automatic logic [cfra_pkg::IN_W-1:0] random_value();
        logic [63:0] b;
        logic [63:0] num;
        logic [31:0] edge_frac[6];
        int unsigned kind;
        edge_frac = '{32'h0, 32'h1, 32'h2, 32'h3, 32'hFFFF_FFFF, 32'hFFFF_FFFE};
        kind = $urandom_range(0, 9);
        if (kind <= 2)
        begin
            b   = 64'(($urandom_range(0, 2) == 0) ? $urandom_range(1, 300)
                                                  : $urandom_range(1, 65535));
            num = 64'($urandom_range(0, 15)) * b + 64'($urandom_range(0, 32'(b - 1)));
            return cfra_pkg::IN_W'((num << 32) / b);
        end
        else if (kind <= 5)
            return cfra_pkg::IN_W'({$urandom, $urandom});
        else if (kind <= 7)
            return {14'd0, 2'($urandom_range(0, 3)), 32'($urandom)};
        else if (kind == 8)
            return {16'($urandom), edge_frac[$urandom_range(0, 5)]};
        else
            return 48'($urandom_range(0, 70000));
    endfunction

    // Offer one value and wait for its transaction
    task automatic offer(input logic [cfra_pkg::IN_W-1:0] v);
        in_valid <= 1'b1;
        in_data  <= v;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Send values in bursts with gaps of random length; valid ends low
    task automatic send_values(input logic [cfra_pkg::IN_W-1:0] vals[$]);
        int unsigned burst_left;
        int unsigned gap;
        burst_left = $urandom_range(1, 6);
        foreach (vals[i])
        begin
            offer(vals[i]);
            burst_left--;
            if (burst_left == 0 || i == vals.size() - 1)
            begin
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 1200)
                                                  : $urandom_range(1, 30);
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
                burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 40)
                                                         : $urandom_range(1, 6);
            end
        end
    endtask

    task automatic send_random(input int unsigned count);
        logic [cfra_pkg::IN_W-1:0] vals[$];
        repeat (count) vals.push_back(random_value());
        send_values(vals);
    endtask

    // Hold until every expected result has arrived
    task automatic drain();
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_limit(input logic [cfra_pkg::CFG_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        @(posedge clk);
    endtask

    logic [cfra_pkg::IN_W-1:0] directed_values[$];
    logic [cfra_pkg::CFG_W-1:0] phase_limit[7];
    int unsigned                phase_items[7];

    initial
    begin
        directed_values = '{
            48'h0000_0000_0000, 48'hFFFF_FFFF_FFFF, 48'h0000_0000_0001, 48'h0000_0000_0002,
            48'h0000_0000_0003, 48'h0001_0000_0000, 48'hFFFF_0000_0000, 48'h0000_8000_0000,
            48'h0003_243F_6A89, 48'h0001_9E37_79B9, 48'h0001_6A09_E668, 48'h0000_5555_5555,
            48'h0000_0001_0000, 48'h0000_0001_0001, 48'h0000_0000_FFFF, 48'h0000_FFFF_FFFF,
            48'h0000_AAAA_AAAA, 48'h0002_B7E1_5163, 48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000,
            48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA
        };
        phase_limit = '{16'd1, 16'd0, 16'd2, 16'd65535, 16'($urandom_range(3, 65534)),
                        16'd255, 16'd65534};
        phase_items = '{30, 30, 50, 110, 130, 100, 110};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed values under the reset limit
        send_values(directed_values);

        // Limit phases; the full-limit phase pauses after its first 40 items until drained
        for (int ph = 0; ph < 7; ph++)
        begin
            drain();
            write_limit(phase_limit[ph]);
            if (phase_limit[ph] == 16'd65535)
            begin
                send_random(40);
                drain();
                send_random(phase_items[ph] - 40);
            end
            else
                send_random(phase_items[ph]);
        end

        drain();
        repeat (100) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("continued_fraction_rational_approx_top regression: pass");
        else
            $display("continued_fraction_rational_approx_top regression: fail");
        $finish;
    end

endmodule

@@ files.f @@
sv/cfra_pkg.sv
sv/continued_fraction_rational_approx_top.sv
sim/cfra_result_monitor.sv
sim/tb.sv
